>>> rtl/b64lw_pkg.sv
// Package: shared constants, types and the symbol table of the base64 line encoder.
package b64lw_pkg;

  localparam int LINE_CHARS = 76;
  localparam int COL_W      = 7;

  localparam logic [7:0] CHAR_NL  = 8'd10;
  localparam logic [7:0] CHAR_PAD = 8'd61;

  // One closed group handed from the front to the back.
  typedef struct packed {
    logic [5:0] s0;
    logic [5:0] s1;
    logic [5:0] s2;
    logic [5:0] s3;
    logic [1:0] have;   // real bytes in the group, 1 to 3
    logic       nl;     // a newline follows the four characters
  } group_t;

  // Front status, watched by the top level.
  typedef struct packed {
    logic [1:0]       pend_cnt;
    logic [COL_W-1:0] column;
  } front_stat_t;

  // Map a 6-bit value to its base64 symbol.
  function automatic logic [7:0] sym(input logic [5:0] v);
    logic [7:0] w;
    begin
      w = {2'b00, v};
      if (v < 6'd26)      sym = w + 8'd65;   // A-Z
      else if (v < 6'd52) sym = w + 8'd71;   // a-z
      else if (v < 6'd62) sym = w - 8'd4;    // 0-9
      else if (v == 6'd62) sym = 8'd43;      // +
      else                 sym = 8'd47;      // /
    end
  endfunction

endpackage

>>> rtl/b64lw_if.sv
// Interfaces: byte input channel and character output channel.
interface b64lw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_final;

  modport source (output valid, output data_byte, output is_final, input ready);
  modport sink   (input valid, input data_byte, input is_final, output ready);
endinterface

interface b64lw_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       run_last;

  modport source (output valid, output out_char, output run_last, input ready);
  modport sink   (input valid, input out_char, input run_last, output ready);
endinterface

>>> rtl/b64lw_front.sv
// Front: gather bytes into groups, split them into sextets, track the line column.
module b64lw_front (
  input  logic                 clk,
  input  logic                 rst_n,
  b64lw_in_if.sink             in_ch,
  output logic                 q_push,
  output b64lw_pkg::group_t    q_entry,
  input  logic                 q_full,
  output b64lw_pkg::front_stat_t stat
);

  logic [1:0]                  held_r;
  logic [7:0]                  a_r, b_r;
  logic [b64lw_pkg::COL_W-1:0] column_r;

  logic                        accept, close_grp, line_full;
  logic [7:0]                  a, b, c;
  logic [b64lw_pkg::COL_W-1:0] col4;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign close_grp   = in_ch.is_final || (held_r == 2'd2);
  assign q_push      = accept && close_grp;

  always_comb begin
    a = (held_r == 2'd0) ? in_ch.data_byte : a_r;
    b = (held_r == 2'd0) ? 8'd0 : ((held_r == 2'd1) ? in_ch.data_byte : b_r);
    c = (held_r == 2'd2) ? in_ch.data_byte : 8'd0;
  end

  assign col4      = column_r + b64lw_pkg::COL_W'(4);
  assign line_full = col4 >= b64lw_pkg::COL_W'(b64lw_pkg::LINE_CHARS);

  always_comb begin
    q_entry.s0   = a[7:2];
    q_entry.s1   = {a[1:0], b[7:4]};
    q_entry.s2   = {b[3:0], c[7:6]};
    q_entry.s3   = c[5:0];
    q_entry.have = held_r + 2'd1;
    // a final byte always leaves a non-empty line unless it was just wrapped
    q_entry.nl   = line_full || in_ch.is_final;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r   <= 2'd0;
      column_r <= '0;
    end else if (accept) begin
      if (close_grp) begin
        held_r   <= 2'd0;
        column_r <= (line_full || in_ch.is_final) ? '0 : col4;
      end else begin
        held_r   <= held_r + 2'd1;
      end
    end
  end

  // hold incoming bytes; no reset needed on payload
  always_ff @(posedge clk) begin
    if (accept && !close_grp) begin
      if (held_r == 2'd0) a_r <= in_ch.data_byte;
      else                b_r <= in_ch.data_byte;
    end
  end

  assign stat.pend_cnt = held_r;
  assign stat.column   = column_r;

endmodule

>>> rtl/b64lw_queue.sv
// Queue: two-entry FIFO of closed groups between front and back.
module b64lw_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  b64lw_pkg::group_t push_entry,
  output logic              full,
  input  logic              pop,
  output logic              valid,
  output b64lw_pkg::group_t pop_entry
);

  b64lw_pkg::group_t mem_r [2];
  logic              wr_ptr_r, rd_ptr_r;
  logic [1:0]        cnt_r;

  assign full      = (cnt_r == 2'd2);
  assign valid     = (cnt_r != 2'd0);
  assign pop_entry = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      if (push && !pop)      cnt_r <= cnt_r + 2'd1;
      else if (pop && !push) cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_entry;
  end

endmodule

>>> rtl/b64lw_back.sv
// Back: emit group characters via an output register, one per cycle unless stalled.
module b64lw_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  b64lw_pkg::group_t q_entry,
  output logic              q_pop,
  b64lw_out_if.source       out_ch
);

  b64lw_pkg::group_t cur_r;
  logic              busy_r;
  logic [2:0]        idx_r;
  logic              out_valid_r, out_last_r;
  logic [7:0]        out_char_r;

  logic [7:0]        char_c;
  logic              last_c, advance, done;

  always_comb begin
    case (idx_r)
      3'd0:    char_c = b64lw_pkg::sym(cur_r.s0);
      3'd1:    char_c = b64lw_pkg::sym(cur_r.s1);
      3'd2:    char_c = (cur_r.have >= 2'd2) ? b64lw_pkg::sym(cur_r.s2) : b64lw_pkg::CHAR_PAD;
      3'd3:    char_c = (cur_r.have == 2'd3) ? b64lw_pkg::sym(cur_r.s3) : b64lw_pkg::CHAR_PAD;
      default: char_c = b64lw_pkg::CHAR_NL;
    endcase
  end

  assign last_c  = ((idx_r == 3'd3) && !cur_r.nl) || (idx_r == 3'd4);
  assign advance = busy_r && (!out_valid_r || out_ch.ready);
  assign done    = advance && last_c;
  assign q_pop   = q_valid && (!busy_r || done);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (q_pop) begin
        busy_r <= 1'b1;
        idx_r  <= 3'd0;
      end else begin
        if (done)    busy_r <= 1'b0;
        if (advance) idx_r  <= idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_entry;
    if (advance) begin
      out_char_r <= char_c;
      out_last_r <= last_c;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_char = out_char_r;
  assign out_ch.run_last = out_last_r;

endmodule

>>> rtl/base64_line_wrapped_encoder_unit.sv
// Top level: MIME base64 encoder with 76-column line wrapping.
// Takes one message byte per request and emits base64 characters, one per request, on
// the output channel. Every third byte, or the byte marked final, closes a group that
// turns into four characters ('=' pads a short final group), followed by a newline when
// the line reaches 76 characters or when the message ends on a non-empty line; the last
// character caused by a byte carries run_last. The front accepts a byte in every cycle
// while the two-entry group queue has room; the back drains the queue at one character
// per cycle while the output channel is ready, so the output port sets the sustained
// rate. A closed group passes through the group queue and the back's group register
// before its first character reaches the output register. A zero-length message cannot
// be expressed.
module base64_line_wrapped_encoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  b64lw_in_if.sink    in_ch,
  b64lw_out_if.source out_ch
);

  logic                   q_push, q_full, q_pop, q_valid;
  b64lw_pkg::group_t      push_entry, pop_entry;
  b64lw_pkg::front_stat_t stat;

  // classify bytes and close groups
  b64lw_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_push  (q_push),
    .q_entry (push_entry),
    .q_full  (q_full),
    .stat    (stat)
  );

  // decouple the byte side from the character side
  b64lw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .valid      (q_valid),
    .pop_entry  (pop_entry)
  );

  // serialize groups into characters
  b64lw_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_entry (pop_entry),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

  // Never push into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full))
    else $error("group queue overflow");

  // A final byte returns the front to its reset state.
  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.is_final) |=>
      (stat.pend_cnt == 2'd0) && (stat.column == '0))
    else $error("front state not cleared after final byte");

  // Column stays below the line length between groups.
  a_column_range: assert property (@(posedge clk) disable iff (!rst_n)
    stat.column < b64lw_pkg::COL_W'(b64lw_pkg::LINE_CHARS))
    else $error("column count out of range");

  // A newline is always the last character of its byte.
  a_nl_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.out_char == b64lw_pkg::CHAR_NL)) |-> out_ch.run_last)
    else $error("newline not marked last");

endmodule

>>> dv/testbench.sv
// Testbench for the base64 line-wrapped encoder: directed and random messages, scoreboarded.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // One expected character together with its end-of-run flag.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } enc_char_t;

  // Standard alphabet, first symbol in the top byte.
  localparam logic [8*64-1:0] B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  logic clk;
  logic rst_n;

  b64lw_in_if  in_ch ();
  b64lw_out_if out_ch ();

  base64_line_wrapped_encoder_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Encoder image used for prediction.
  logic [15:0] held_bytes;
  logic [1:0]  held_count;
  logic [6:0]  line_column;

  enc_char_t expected_chars[$];
  int        mismatches;

  // Sender burst control and receiver hold-off request.
  int burst_left;
  bit gaps_off;
  int hold_request;

  always #1 clk = ~clk;

  // Drive every input to a known value from time zero.
  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.is_final  = 1'b0;
    out_ch.ready    = 1'b0;
  end

  // Hard stop in case the block hangs.
  initial begin
    #400000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // ------------------------------------------------------------------
  // Prediction
  // ------------------------------------------------------------------

  function automatic logic [7:0] b64_symbol(input logic [5:0] v);
    b64_symbol = B64_ALPHABET[8*(63 - int'(v)) +: 8];
  endfunction

  function automatic void push_char(input logic [7:0] ch);
    enc_char_t e;
    e.ch   = ch;
    e.last = 1'b0;
    expected_chars.push_back(e);
  endfunction

  // Advance the encoder image by one accepted byte and queue what it causes.
  task automatic encode_byte(input logic [7:0] data, input logic fin);
    logic [7:0] a, b, c;
    int         have;
    enc_char_t  tail;
    begin
      // A byte that leaves the group open is only stored.
      if (held_count < 2'd2 && !fin) begin
        if (held_count == 2'd0) held_bytes = {data, 8'h00};
        else                    held_bytes = {held_bytes[15:8], data};
        held_count = held_count + 2'd1;
      end else begin
        have = int'(held_count) + 1;
        a = (held_count == 2'd0) ? data : held_bytes[15:8];
        b = (held_count == 2'd0) ? 8'h00 : (held_count == 2'd1) ? data : held_bytes[7:0];
        c = (held_count == 2'd2) ? data : 8'h00;
        push_char(b64_symbol(a[7:2]));
        push_char(b64_symbol({a[1:0], b[7:4]}));
        push_char(have >= 2 ? b64_symbol({b[3:0], c[7:6]}) : b64lw_pkg::CHAR_PAD);
        push_char(have >= 3 ? b64_symbol(c[5:0]) : b64lw_pkg::CHAR_PAD);
        // Wrap once the line reaches its width, even when the width is not a multiple of four.
        line_column = line_column + 7'd4;
        if (int'(line_column) >= b64lw_pkg::LINE_CHARS) begin
          push_char(b64lw_pkg::CHAR_NL);
          line_column = '0;
        end
        held_bytes = '0;
        held_count = '0;
        if (fin) begin
          // Close a non-empty line at message end, then start from scratch.
          if (line_column != '0) push_char(b64lw_pkg::CHAR_NL);
          line_column = '0;
        end
        tail      = expected_chars.pop_back();
        tail.last = 1'b1;
        expected_chars.push_back(tail);
      end
    end
  endtask

  // ------------------------------------------------------------------
  // Sender: bursts of random length separated by random gaps
  // ------------------------------------------------------------------

  task automatic send_byte(input logic [7:0] data, input logic fin);
    int gap;
    begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
        if (gaps_off) gap = 0;
        if (gap > 0) begin
          @(negedge clk);
          in_ch.valid <= 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
      end
      burst_left = burst_left - 1;
      // Offer the request and hold it until the block takes it.
      @(negedge clk);
      in_ch.valid     <= 1'b1;
      in_ch.data_byte <= data;
      in_ch.is_final  <= fin;
      do @(posedge clk); while (!in_ch.ready);
      encode_byte(data, fin);
    end
  endtask

  // Send a whole message of random content; length must be at least one.
  task automatic send_message(input int len, input bit corner_bias);
    logic [7:0] d;
    begin
      for (int i = 0; i < len; i++) begin
        d = $urandom_range(0, 255);
        // Lean on all-zero and all-one bytes now and then.
        if (corner_bias && $urandom_range(0, 3) == 0) d = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        send_byte(d, i == len - 1);
      end
    end
  endtask

  // ------------------------------------------------------------------
  // Receiver: stall pattern of its own, plus a long hold-off on request
  // ------------------------------------------------------------------

  initial begin
    int         hold_left;
    int         phase_left;
    bit         stall_on;
    logic [10:0] stall_pattern;
    hold_left     = 0;
    phase_left    = 0;
    stall_on      = 1'b0;
    stall_pattern = '1;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (phase_left == 0) begin
        // Pick at random between free-running stretches and patterned stalls.
        phase_left    = $urandom_range(20, 90);
        stall_on      = $urandom_range(0, 2) != 0;
        stall_pattern = $urandom_range(0, 2047);
      end
      phase_left = phase_left - 1;
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_ch.ready <= 1'b0;
      end else if (!stall_on) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready  <= stall_pattern[0];
        stall_pattern = {stall_pattern[0], stall_pattern[10:1]};
      end
    end
  end

  // ------------------------------------------------------------------
  // Checker: compare each accepted character with the oldest expectation
  // ------------------------------------------------------------------

  always @(posedge clk) begin
    enc_char_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_chars.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10)
          $display("unexpected char 0x%02h last=%0b", out_ch.out_char, out_ch.run_last);
      end else begin
        want = expected_chars.pop_front();
        if (out_ch.out_char !== want.ch || out_ch.run_last !== want.last) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("char mismatch: expected 0x%02h last=%0b, got 0x%02h last=%0b",
                     want.ch, want.last, out_ch.out_char, out_ch.run_last);
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------

  // Short messages: extreme bytes and both padding forms.
  task automatic test_short_groups;
    begin
      send_byte(8'h00, 1'b1);                    // lone final byte, two pads
      send_byte(8'hFF, 1'b1);
      send_byte(8'hFF, 1'b0);                    // final byte second in group, one pad
      send_byte(8'hFF, 1'b1);
      send_byte(8'h80, 1'b0);
      send_byte(8'h01, 1'b1);
    end
  endtask

  // Full groups: no padding, the top symbols and a known word.
  task automatic test_full_groups;
    begin
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFB, 1'b0);                    // maps to symbol 62, '+', four times
      send_byte(8'hEF, 1'b0);
      send_byte(8'hBE, 1'b1);
      send_byte(8'h4D, 1'b0);
      send_byte(8'h61, 1'b0);
      send_byte(8'h6E, 1'b1);
    end
  endtask

  // Line wrap: end exactly on a full line, and one group past it.
  task automatic test_line_wrap;
    begin
      send_message(57, 1'b0);                    // wrap newline only, none at message end
      send_message(58, 1'b0);                    // wrap, then a final group on a fresh line
    end
  endtask

  // Hold the receiver off while the sender keeps pushing, so the input stalls.
  task automatic test_backpressure;
    begin
      gaps_off     = 1'b1;
      burst_left   = 0;
      hold_request = 300;
      send_message(45, 1'b0);
      gaps_off     = 1'b0;
    end
  endtask

  // Random messages, mostly short, some long enough to wrap.
  task automatic test_random_messages;
    int sent;
    int len;
    int pick;
    begin
      sent = 0;
      while (sent < 120) begin
        pick = $urandom_range(0, 9);
        if (pick < 7)      len = $urandom_range(1, 12);
        else if (pick < 9) len = $urandom_range(13, 40);
        else               len = $urandom_range(41, 90);
        send_message(len, $urandom_range(0, 1));
        sent = sent + len;
      end
    end
  endtask

  // ------------------------------------------------------------------
  // Sequencing
  // ------------------------------------------------------------------

  initial begin
    int drain_wait;
    held_bytes   = '0;
    held_count   = '0;
    line_column  = '0;
    mismatches   = 0;
    burst_left   = 0;
    gaps_off     = 1'b0;
    hold_request = 0;

    // Apply reset once, release it away from the sampling edge.
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_short_groups();
    test_full_groups();
    test_line_wrap();
    test_backpressure();
    test_random_messages();

    @(negedge clk);
    in_ch.valid <= 1'b0;

    // Drain, then watch a little longer for stray characters.
    drain_wait = 0;
    while (expected_chars.size() != 0 && drain_wait < 20000) begin
      @(posedge clk);
      drain_wait = drain_wait + 1;
    end
    repeat (20) @(posedge clk);

    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
